[rtl/sbht_pkg.sv]
// Shared constants and types for the segment band hit test.
// No dependencies; used by sbht_wmul and segment_band_hit_test_top.
`default_nettype none

package sbht_pkg;

  // Configuration register file
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEAR_LENGTH = 1'b0,
    CFG_TEAR_WIDTH  = 1'b1
  } cfg_reg_e;

  localparam logic [CFG_DATA_W-1:0] TEAR_LENGTH_RST = 16'd77;
  localparam logic [CFG_DATA_W-1:0] TEAR_WIDTH_RST  = 16'd5;

  // Fixed field widths
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned SCALE_W   = 12;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned FRAC_BITS = 8;

  // Scaled length/width (Q12.8) and their squares
  localparam int unsigned SL_W  = LEN_W + SCALE_W - FRAC_BITS;
  localparam int unsigned SL2_W = 2 * SL_W;

  // Wide multiplier: chunk size of one partial product, and its latency
  localparam int unsigned MUL_CHUNK = 32;
  localparam int unsigned MUL_LAT   = 3;

endpackage

`default_nettype wire

[rtl/sbht_wmul.sv]
// Pipelined unsigned wide multiplier, split into chunk-by-chunk partial products.
// Three register stages: partial products, row sums, final sum. Uses sbht_pkg.
`default_nettype none

module sbht_wmul #(
  parameter int unsigned AW = 34,
  parameter int unsigned BW = 34
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [AW-1:0]    a_i,
  input  wire logic [BW-1:0]    b_i,
  output logic      [AW+BW-1:0] p_o
);

  localparam int unsigned CW = sbht_pkg::MUL_CHUNK;
  localparam int unsigned NA = (AW + CW - 1) / CW;
  localparam int unsigned NB = (BW + CW - 1) / CW;
  localparam int unsigned RW = (NB + 1) * CW;
  localparam int unsigned PW = (NA + NB) * CW;

  logic [NA*CW-1:0] a_ext;
  logic [NB*CW-1:0] b_ext;

  logic [2*CW-1:0] pp_d [NA][NB];
  logic [2*CW-1:0] pp_q [NA][NB];
  logic [RW-1:0]   row_d [NA];
  logic [RW-1:0]   row_q [NA];
  logic [PW-1:0]   prod_d;
  logic [PW-1:0]   prod_q;

  assign a_ext = (NA*CW)'(a_i);
  assign b_ext = (NB*CW)'(b_i);

  // stage 1: chunk products
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_d[i][j] = (2*CW)'(a_ext[i*CW +: CW]) * (2*CW)'(b_ext[j*CW +: CW]);
      end
    end
  end

  // stage 2: one row per chunk of a
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (RW'(pp_q[i][j]) << (j * CW));
      end
    end
  end

  // stage 3: add the rows
  always_comb begin
    prod_d = '0;
    for (int i = 0; i < NA; i++) begin
      prod_d = prod_d + (PW'(row_q[i]) << (i * CW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= pp_d[i][j];
        end
        row_q[i] <= row_d[i];
      end
      prod_q <= prod_d;
    end
  end

  assign p_o = prod_q[AW+BW-1:0];

endmodule

`default_nettype wire

[rtl/segment_band_hit_test_top.sv]
// Segment band hit test: top level with config registers, front pipeline and output queue.
// Depends on sbht_pkg and sbht_wmul.
// An accepted word passes stages 1-3, the wide multipliers and the output queue in order.
// Throughput: one word per cycle; the whole pipeline holds while the 2-entry output
// queue is full, so in_stall_o comes from a register, not from out_stall_i.
// Reset clears all valid bits and the output queue; tear_length = 77, tear_width = 5.
`default_nettype none

module segment_band_hit_test_top #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                cfg_we_i,
  input  wire logic [sbht_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [sbht_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [COORD_BITS-1:0]        particle_x_i,
  input  wire logic signed [COORD_BITS-1:0]        particle_y_i,
  input  wire logic signed [COORD_BITS-1:0]        particle_z_i,
  input  wire logic signed [COORD_BITS-1:0]        center_x_i,
  input  wire logic signed [COORD_BITS-1:0]        center_y_i,
  input  wire logic signed [COORD_BITS-1:0]        center_z_i,
  input  wire logic signed [COORD_BITS-1:0]        dir_x_i,
  input  wire logic signed [COORD_BITS-1:0]        dir_y_i,
  input  wire logic signed [COORD_BITS-1:0]        dir_z_i,
  input  wire logic [sbht_pkg::SCALE_W-1:0]        size_factor_i,
  input  wire logic [sbht_pkg::IDX_W-1:0]          particle_index_i,
  // output channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [sbht_pkg::IDX_W-1:0]               result_index_o,
  output logic                                     hit_o
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned RW    = CB + 1;          // r = p - c
  localparam int unsigned RDW   = 2 * CB + 1;      // r_i * d_i
  localparam int unsigned SQW   = 2 * CB + 2;      // squares before trimming
  localparam int unsigned RRW   = 2 * CB;          // r_i^2, d_i^2
  localparam int unsigned DOTW  = 2 * CB + 3;      // signed dot sum
  localparam int unsigned DW    = 2 * CB + 1;      // |r.d|
  localparam int unsigned R2W   = 2 * CB + 2;      // |r|^2
  localparam int unsigned D2W   = 2 * CB;          // |d|^2
  localparam int unsigned LW    = sbht_pkg::LEN_W;
  localparam int unsigned SW    = sbht_pkg::SCALE_W;
  localparam int unsigned IW    = sbht_pkg::IDX_W;
  localparam int unsigned SLW   = sbht_pkg::SL_W;
  localparam int unsigned SL2W  = sbht_pkg::SL2_W;
  localparam int unsigned LAT   = sbht_pkg::MUL_LAT;
  localparam int unsigned P1W   = 2 * DW;
  localparam int unsigned P2W   = R2W + D2W;
  localparam int unsigned P3W   = SL2W + D2W;
  localparam int unsigned CMPW  = ((P1W > P3W) ? P1W : P3W) + 3;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [LW-1:0] tear_length_q;
  logic [LW-1:0] tear_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tear_length_q <= sbht_pkg::TEAR_LENGTH_RST;
      tear_width_q  <= sbht_pkg::TEAR_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (sbht_pkg::cfg_reg_e'(cfg_idx_i))
        sbht_pkg::CFG_TEAR_LENGTH: tear_length_q <= cfg_data_i;
        sbht_pkg::CFG_TEAR_WIDTH:  tear_width_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Global advance: pipeline moves while the output queue has room
  logic       en;
  logic [1:0] cnt_q;

  assign en         = (cnt_q != 2'd2);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------------------
  // Stage 1: offsets, zero-direction flag, scaled length and width
  logic                   s1_valid_q;
  logic signed [RW-1:0]   r_d  [3];
  logic signed [RW-1:0]   r1_q [3];
  logic signed [CB-1:0]   d1_q [3];
  logic [LW+SW-1:0]       sl_full;
  logic [LW+SW-1:0]       sw_full;
  logic [SLW-1:0]         sl1_q;
  logic [SLW-1:0]         sw1_q;
  logic                   dz1_q;
  logic [IW-1:0]          idx1_q;

  assign r_d[0] = RW'(particle_x_i) - RW'(center_x_i);
  assign r_d[1] = RW'(particle_y_i) - RW'(center_y_i);
  assign r_d[2] = RW'(particle_z_i) - RW'(center_z_i);
  assign sl_full = (LW+SW)'(tear_length_q) * (LW+SW)'(size_factor_i);
  assign sw_full = (LW+SW)'(tear_width_q) * (LW+SW)'(size_factor_i);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q   <= r_d;
      d1_q[0] <= dir_x_i;
      d1_q[1] <= dir_y_i;
      d1_q[2] <= dir_z_i;
      sl1_q  <= sl_full[LW+SW-1:sbht_pkg::FRAC_BITS];
      sw1_q  <= sw_full[LW+SW-1:sbht_pkg::FRAC_BITS];
      dz1_q  <= (dir_x_i == '0) && (dir_y_i == '0) && (dir_z_i == '0);
      idx1_q <= particle_index_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: per-axis products and squared scale terms
  logic                   s2_valid_q;
  logic signed [RDW-1:0]  rd_d  [3];
  logic signed [RDW-1:0]  rd2_q [3];
  logic signed [SQW-1:0]  rsq_d [3];
  logic signed [SQW-1:0]  dsq_d [3];
  logic [RRW-1:0]         rr2_q [3];
  logic [RRW-1:0]         dd2_q [3];
  logic [SL2W-1:0]        sl2_q;
  logic [SL2W-1:0]        sw2_q;
  logic                   dz2_q;
  logic [IW-1:0]          idx2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rd_d[i]  = RDW'(r1_q[i]) * RDW'(d1_q[i]);
      rsq_d[i] = SQW'(r1_q[i]) * SQW'(r1_q[i]);
      dsq_d[i] = SQW'(d1_q[i]) * SQW'(d1_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rd2_q[i] <= rd_d[i];
        rr2_q[i] <= rsq_d[i][RRW-1:0];
        dd2_q[i] <= dsq_d[i][RRW-1:0];
      end
      sl2_q  <= SL2W'(sl1_q) * SL2W'(sl1_q);
      sw2_q  <= SL2W'(sw1_q) * SL2W'(sw1_q);
      dz2_q  <= dz1_q;
      idx2_q <= idx1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: dot product magnitude, |r|^2, |d|^2
  logic                   s3_valid_q;
  logic signed [DOTW-1:0] dot_s;
  logic [DOTW-1:0]        dot_abs;
  logic [R2W-1:0]         r2_sum;
  logic [D2W-1:0]         d2_sum;
  logic [DW-1:0]          dot3_q;
  logic [R2W-1:0]         r23_q;
  logic [D2W-1:0]         d23_q;
  logic [SL2W-1:0]        sl3_q;
  logic [SL2W-1:0]        sw3_q;
  logic                   dz3_q;
  logic [IW-1:0]          idx3_q;

  assign dot_s   = DOTW'(rd2_q[0]) + DOTW'(rd2_q[1]) + DOTW'(rd2_q[2]);
  assign dot_abs = dot_s[DOTW-1] ? DOTW'(-dot_s) : DOTW'(dot_s);
  assign r2_sum  = R2W'(rr2_q[0]) + R2W'(rr2_q[1]) + R2W'(rr2_q[2]);
  assign d2_sum  = dd2_q[0] + dd2_q[1] + dd2_q[2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dot3_q <= dot_abs[DW-1:0];
      r23_q  <= r2_sum;
      d23_q  <= d2_sum;
      sl3_q  <= sl2_q;
      sw3_q  <= sw2_q;
      dz3_q  <= dz2_q;
      idx3_q <= idx2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 4-6: wide products
  logic [P1W-1:0] dot2;
  logic [P2W-1:0] rd2prod;
  logic [P3W-1:0] lprod;
  logic [P3W-1:0] wprod;

  sbht_wmul #(.AW(DW), .BW(DW)) u_mul_dot (
    .clk_i (clk_i), .en_i (en), .a_i (dot3_q), .b_i (dot3_q), .p_o (dot2)
  );

  sbht_wmul #(.AW(R2W), .BW(D2W)) u_mul_rd (
    .clk_i (clk_i), .en_i (en), .a_i (r23_q), .b_i (d23_q), .p_o (rd2prod)
  );

  sbht_wmul #(.AW(SL2W), .BW(D2W)) u_mul_len (
    .clk_i (clk_i), .en_i (en), .a_i (sl3_q), .b_i (d23_q), .p_o (lprod)
  );

  sbht_wmul #(.AW(SL2W), .BW(D2W)) u_mul_wid (
    .clk_i (clk_i), .en_i (en), .a_i (sw3_q), .b_i (d23_q), .p_o (wprod)
  );

  // sideband delay matching the multiplier latency
  logic          mv_q   [LAT];
  logic          mdz_q  [LAT];
  logic [IW-1:0] midx_q [LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      mdz_q[0]  <= dz3_q;
      midx_q[0] <= idx3_q;
      for (int k = 1; k < LAT; k++) begin
        mdz_q[k]  <= mdz_q[k-1];
        midx_q[k] <= midx_q[k-1];
      end
    end
  end

  // valid bits for all stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      for (int k = 0; k < LAT; k++) begin
        mv_q[k] <= 1'b0;
      end
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      mv_q[0]    <= s3_valid_q;
      for (int k = 1; k < LAT; k++) begin
        mv_q[k] <= mv_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Final compare: along and across tests, both inclusive
  logic along_ok;
  logic across_ok;
  logic hit_d;
  logic push;
  logic pop;

  assign along_ok  = (CMPW'(dot2) << 2) <= CMPW'(lprod);
  assign across_ok = CMPW'(rd2prod) <= (CMPW'(wprod) + CMPW'(dot2));
  assign hit_d     = !mdz_q[LAT-1] && along_ok && across_ok;

  assign push = en && mv_q[LAT-1];
  assign pop  = out_valid_o && !out_stall_i;

  // ---------------------------------------------------------------------------
  // Two-entry output queue
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    cnt_d;
  logic [IW-1:0] q_idx_q [2];
  logic          q_hit_q [2];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_idx_q[wr_ptr_q] <= midx_q[LAT-1];
      q_hit_q[wr_ptr_q] <= hit_d;
    end
  end

  assign out_valid_o    = (cnt_q != 2'd0);
  assign result_index_o = q_idx_q[rd_ptr_q];
  assign hit_o          = q_hit_q[rd_ptr_q];

  // ---------------------------------------------------------------------------
  // Assertions
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output queue count out of range");

  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] == (wr_ptr_q ^ rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1))
    else $error("queue count did not drop after a pop");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(s1_valid_q) && $stable(s3_valid_q) && $stable(mv_q[LAT-1])))
    else $error("pipeline moved while held");

endmodule

`default_nettype wire
